// ===== sv/ds_pkg.sv =====
// Shared types, constants and the CORDIC step-angle table of the direction slerp.
// No dependencies; every other file imports it.
package ds_pkg;

  localparam int ANGLE_BITS   = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 48;
  localparam int CW           = 34;
  localparam int ZW           = 35;
  localparam int AW           = 32;
  localparam int SW           = 31;
  localparam int WW           = DIV_STEPS + 1;

  localparam logic [AW-1:0]        PI_Q       = 32'd3373259426;
  localparam logic [AW-1:0]        HALF_PI_Q  = 32'd1686629713;
  localparam logic signed [CW-1:0] GAIN_INV_Q = 34'sd652032874;
  localparam logic [SW-1:0]        SINE_FLOOR = 31'd10737;
  localparam logic [16:0]          BLEND_ONE  = 17'd65536;

  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
    logic [16:0]        blend;
  } ds_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } ds_out_t;

  typedef struct packed {
    ds_in_t             item;
    logic signed [31:0] c;
    logic [SW-1:0]      s;
    logic               small_sine;
  } ds_side_t;

  function automatic logic signed [ZW-1:0] step_angle(input int i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:  a = 35'sd843314857;
      1:  a = 35'sd497837829;
      2:  a = 35'sd263043837;
      3:  a = 35'sd133525159;
      4:  a = 35'sd67021688;
      5:  a = 35'sd33543516;
      6:  a = 35'sd16775851;
      7:  a = 35'sd8388437;
      8:  a = 35'sd4194283;
      9:  a = 35'sd2097149;
      10: a = 35'sd1048576;
      default: a = ZW'(64'sd1 <<< (ANGLE_BITS - i));
    endcase
    return a;
  endfunction

endpackage

// ===== sv/ds_cordic.sv =====
// Pipelined CORDIC, one micro-rotation per register stage, vectoring or rotation mode.
// Depends on ds_pkg.
module ds_cordic #(
  parameter bit VECTORING = 1'b0
) (
  input  logic                        clk,
  input  logic signed [ds_pkg::CW-1:0] x_i,
  input  logic signed [ds_pkg::CW-1:0] y_i,
  input  logic signed [ds_pkg::ZW-1:0] z_i,
  output logic signed [ds_pkg::CW-1:0] x_o,
  output logic signed [ds_pkg::CW-1:0] y_o,
  output logic signed [ds_pkg::ZW-1:0] z_o
);
  import ds_pkg::*;

  logic signed [CW-1:0] x_r [CORDIC_STEPS];
  logic signed [CW-1:0] y_r [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in;
    logic                 ccw;
    if (i == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = z_i;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
    end
    assign dx  = y_in >>> i;
    assign dy  = x_in >>> i;
    assign ccw = VECTORING ? y_in[CW-1] : !z_in[ZW-1];
    always_ff @(posedge clk) begin
      if (ccw) begin
        x_r[i] <= x_in - dx;
        y_r[i] <= y_in + dy;
        z_r[i] <= z_in - step_angle(i);
      end else begin
        x_r[i] <= x_in + dx;
        y_r[i] <= y_in - dy;
        z_r[i] <= z_in + step_angle(i);
      end
    end
  end

  assign x_o = x_r[CORDIC_STEPS-1];
  assign y_o = y_r[CORDIC_STEPS-1];
  assign z_o = z_r[CORDIC_STEPS-1];

endmodule

// ===== sv/ds_divide.sv =====
// Pipelined restoring divider for the slerp weights: (num << 30) / den, truncated to zero.
// One quotient bit per stage plus a sign stage; depends on ds_pkg.
module ds_divide (
  input  logic                         clk,
  input  logic signed [ds_pkg::CW-1:0] num_i,
  input  logic [ds_pkg::SW-1:0]        den_i,
  output logic signed [ds_pkg::WW-1:0] quo_o
);
  import ds_pkg::*;

  localparam int DV = CW + ANGLE_BITS;

  logic [CW-1:0]        mag;
  logic [DV-1:0]        dvd;
  logic [31:0]          rem_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] dl_r  [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r   [DIV_STEPS];
  logic [SW-1:0]        den_r [DIV_STEPS];
  logic                 neg_r [DIV_STEPS];
  logic signed [WW-1:0] quo_r;

  assign mag = num_i[CW-1] ? CW'(-num_i) : CW'(num_i);
  assign dvd = {mag, {ANGLE_BITS{1'b0}}};

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [31:0]          rem_in, rem_nxt;
    logic [DIV_STEPS-1:0] dl_in, q_in;
    logic [SW-1:0]        den_in;
    logic                 neg_in, ge;
    logic [32:0]          rem_sh;
    if (k == 0) begin : g_first
      assign rem_in = 32'(dvd[DV-1:DIV_STEPS]);
      assign dl_in  = dvd[DIV_STEPS-1:0];
      assign q_in   = '0;
      assign den_in = den_i;
      assign neg_in = num_i[CW-1];
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dl_in  = dl_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
      assign neg_in = neg_r[k-1];
    end
    assign rem_sh  = {rem_in, dl_in[DIV_STEPS-1]};
    assign ge      = rem_sh >= 33'(den_in);
    assign rem_nxt = ge ? 32'(rem_sh - 33'(den_in)) : rem_sh[31:0];
    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      dl_r[k]  <= dl_in << 1;
      q_r[k]   <= {q_in[DIV_STEPS-2:0], ge};
      den_r[k] <= den_in;
      neg_r[k] <= neg_in;
    end
  end

  always_ff @(posedge clk) begin
    if (neg_r[DIV_STEPS-1]) begin
      quo_r <= -$signed({1'b0, q_r[DIV_STEPS-1]});
    end else begin
      quo_r <= $signed({1'b0, q_r[DIV_STEPS-1]});
    end
  end

  assign quo_o = quo_r;

endmodule

// ===== sv/direction_slerp.sv =====
// Top level of the direction slerp: dot product, square root, CORDIC angle and sines,
// weight division and blend. Depends on ds_pkg, ds_cordic and ds_divide.
//
// Takes one vector pair per clock (busy stays low) and returns one result per clock, in
// order, through a fully pipelined chain: 32 square-root stages, three 30-stage CORDIC
// units (one for the angle, two sine lanes side by side) and two 48-stage dividers side
// by side, plus the front end and blend.
// out_valid marks each result for exactly one cycle; the receiver cannot stall it.
module direction_slerp #(
  parameter int FRACTION_BITS = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ds_pkg::ds_in_t  in_item,
  output logic            out_valid,
  output ds_pkg::ds_out_t out_item
);
  import ds_pkg::*;

  localparam int IX_C   = 1;
  localparam int IX_N   = 2;
  localparam int IX_S   = IX_N + SQRT_STEPS + 1;
  localparam int IX_A   = IX_S + CORDIC_STEPS + 1;
  localparam int IX_TH  = IX_A + 1;
  localparam int IX_ROT = IX_TH + CORDIC_STEPS;
  localparam int IX_DIV = IX_ROT + DIV_STEPS + 1;
  localparam int IX_P   = IX_DIV + 1;
  localparam int SD_LEN = IX_P + 1;
  localparam int SHIFT  = 2 * FRACTION_BITS - ANGLE_BITS;

  ds_side_t             sd_r   [SD_LEN];
  ds_side_t             sd_nxt [SD_LEN];
  logic [SD_LEN-1:0]    vd_r;
  logic signed [31:0]   prod_r [3];
  logic signed [63:0]   dot_w, one_w, dot_cl;
  logic signed [31:0]   c_w;
  logic signed [63:0]   cc_w;
  logic [63:0]          n_r;
  logic [63:0]          sq_n_r [SQRT_STEPS];
  logic [63:0]          sq_q_r [SQRT_STEPS];
  logic [SW-1:0]        s_w;
  logic [16:0]          blend_cl;
  logic signed [CW-1:0] vx_in, vy_in;
  logic signed [ZW-1:0] vz_in, vz_out;
  logic [AW-1:0]        a_cl, a_r, ta_r, ra_w;
  logic [48:0]          ab_w;
  logic [AW-1:0]        th_ra_r, th_ta_r;
  logic signed [CW-1:0] sin_ra, sin_ta;
  logic signed [WW-1:0] wa, wb;
  logic signed [64:0]   pa_r [3];
  logic signed [64:0]   pb_r [3];
  logic signed [15:0]   fv [3];
  logic signed [15:0]   tv [3];
  logic signed [15:0]   tq [3];
  logic signed [15:0]   res_w [3];
  ds_out_t              out_nxt;
  ds_out_t              out_r;
  logic                 out_valid_r;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -36'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign busy = 1'b0;

  // front end: products, clamp, cosine in Q30
  assign blend_cl = (in_item.blend > BLEND_ONE) ? BLEND_ONE : in_item.blend;

  always_ff @(posedge clk) begin
    prod_r[0] <= in_item.from_x * in_item.to_x;
    prod_r[1] <= in_item.from_y * in_item.to_y;
    prod_r[2] <= in_item.from_z * in_item.to_z;
  end

  assign dot_w  = 64'(prod_r[0]) + 64'(prod_r[1]) + 64'(prod_r[2]);
  assign one_w  = 64'sd1 <<< (2 * FRACTION_BITS);
  assign dot_cl = (dot_w > one_w) ? one_w : ((dot_w < -one_w) ? -one_w : dot_w);

  if (SHIFT >= 0) begin : g_cdown
    assign c_w = 32'(dot_cl >>> SHIFT);
  end else begin : g_cup
    assign c_w = 32'(dot_cl <<< (-SHIFT));
  end

  assign cc_w = sd_r[IX_N-1].c * sd_r[IX_N-1].c;

  always_ff @(posedge clk) begin
    n_r <= 64'((64'sd1 <<< 60) - cc_w);
  end

  // square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [63:0] nn_in, rr_in, trial;
    if (j == 0) begin : g_first
      assign nn_in = n_r;
      assign rr_in = '0;
    end else begin : g_next
      assign nn_in = sq_n_r[j-1];
      assign rr_in = sq_q_r[j-1];
    end
    assign trial = rr_in + (64'd1 << (62 - 2 * j));
    always_ff @(posedge clk) begin
      if (nn_in >= trial) begin
        sq_n_r[j] <= nn_in - trial;
        sq_q_r[j] <= (rr_in >> 1) + (64'd1 << (62 - 2 * j));
      end else begin
        sq_n_r[j] <= nn_in;
        sq_q_r[j] <= rr_in >> 1;
      end
    end
  end

  assign s_w = sq_q_r[SQRT_STEPS-1][SW-1:0];

  // side line: item, cosine, sine and valid travel alongside the units
  for (genvar k = 0; k < SD_LEN; k++) begin : g_side
    always_comb begin
      if (k == 0) begin
        sd_nxt[k].item       = in_item;
        sd_nxt[k].item.blend = blend_cl;
        sd_nxt[k].c          = '0;
        sd_nxt[k].s          = '0;
        sd_nxt[k].small_sine = 1'b0;
      end else if (k == IX_C) begin
        sd_nxt[k]   = sd_r[k-1];
        sd_nxt[k].c = c_w;
      end else if (k == IX_S) begin
        sd_nxt[k]            = sd_r[k-1];
        sd_nxt[k].s          = s_w;
        sd_nxt[k].small_sine = s_w < SINE_FLOOR;
      end else begin
        sd_nxt[k] = sd_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      sd_r[k] <= sd_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vd_r        <= {vd_r[SD_LEN-2:0], start};
      out_valid_r <= vd_r[SD_LEN-1];
    end
  end

  // angle between the vectors
  always_comb begin
    if (sd_r[IX_S].c < 0) begin
      vx_in = CW'(sd_r[IX_S].s);
      vy_in = -CW'(sd_r[IX_S].c);
      vz_in = ZW'(HALF_PI_Q);
    end else begin
      vx_in = CW'(sd_r[IX_S].c);
      vy_in = CW'(sd_r[IX_S].s);
      vz_in = '0;
    end
  end

  ds_cordic #(.VECTORING(1'b1)) u_angle (
    .clk (clk),
    .x_i (vx_in),
    .y_i (vy_in),
    .z_i (vz_in),
    .x_o (),
    .y_o (),
    .z_o (vz_out)
  );

  assign a_cl = vz_out[ZW-1] ? '0 :
                ((vz_out > $signed(ZW'(PI_Q))) ? PI_Q : vz_out[AW-1:0]);
  assign ab_w = a_cl * sd_r[IX_A-1].item.blend;
  assign ra_w = a_r - ta_r;

  always_ff @(posedge clk) begin
    a_r     <= a_cl;
    ta_r    <= ab_w[47:16];
    th_ra_r <= (ra_w > HALF_PI_Q) ? PI_Q - ra_w : ra_w;
    th_ta_r <= (ta_r > HALF_PI_Q) ? PI_Q - ta_r : ta_r;
  end

  // the two sines
  ds_cordic #(.VECTORING(1'b0)) u_sin_ra (
    .clk (clk),
    .x_i (GAIN_INV_Q),
    .y_i ('0),
    .z_i (ZW'(th_ra_r)),
    .x_o (),
    .y_o (sin_ra),
    .z_o ()
  );

  ds_cordic #(.VECTORING(1'b0)) u_sin_ta (
    .clk (clk),
    .x_i (GAIN_INV_Q),
    .y_i ('0),
    .z_i (ZW'(th_ta_r)),
    .x_o (),
    .y_o (sin_ta),
    .z_o ()
  );

  // weights
  ds_divide u_div_a (
    .clk   (clk),
    .num_i (sin_ra),
    .den_i (sd_r[IX_ROT].s),
    .quo_o (wa)
  );

  ds_divide u_div_b (
    .clk   (clk),
    .num_i (sin_ta),
    .den_i (sd_r[IX_ROT].s),
    .quo_o (wb)
  );

  // blend
  assign fv[0] = sd_r[IX_DIV].item.from_x;
  assign fv[1] = sd_r[IX_DIV].item.from_y;
  assign fv[2] = sd_r[IX_DIV].item.from_z;
  assign tv[0] = sd_r[IX_DIV].item.to_x;
  assign tv[1] = sd_r[IX_DIV].item.to_y;
  assign tv[2] = sd_r[IX_DIV].item.to_z;
  assign tq[0] = sd_r[IX_P].item.to_x;
  assign tq[1] = sd_r[IX_P].item.to_y;
  assign tq[2] = sd_r[IX_P].item.to_z;

  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic signed [65:0] acc;
    always_ff @(posedge clk) begin
      pa_r[j] <= wa * fv[j];
      pb_r[j] <= wb * tv[j];
    end
    assign acc      = 66'(pa_r[j]) + 66'(pb_r[j]) + (66'sd1 <<< (ANGLE_BITS - 1));
    assign res_w[j] = sd_r[IX_P].small_sine ? tq[j] : sat16(36'(acc >>> ANGLE_BITS));
  end

  always_comb begin
    out_nxt.out_x = res_w[0];
    out_nxt.out_y = res_w[1];
    out_nxt.out_z = res_w[2];
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== bench/direction_slerp_checker.sv =====
// Checker for the direction slerp: watches transfers in and results out, predicts each result
// and compares it field by field. Depends on ds_pkg.
module direction_slerp_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  ds_pkg::ds_in_t  in_item,
  input  logic            out_valid,
  input  ds_pkg::ds_out_t out_item,
  output int              fail_count,
  output int              pending
);
  import ds_pkg::*;

  localparam longint ANGLE_ONE = 64'sd1 << 30;

  ds_out_t slerp_results[$];

  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint angle_step(int i);
    longint tbl [0:10];
    tbl = '{843314857, 497837829, 263043837, 133525159, 67021688, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return tbl[i];
    return 64'sd1 << (30 - i);
  endfunction

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint pair_angle(longint c, longint s);
    longint x, y, z, dx, dy;
    if (c < 0) begin
      x = s; y = -c; z = 1686629713;
    end else begin
      x = c; y = s; z = 0;
    end
    for (int i = 0; i < 30; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += angle_step(i);
      end else begin
        x -= dx; y += dy; z -= angle_step(i);
      end
    end
    if (z < 0) z = 0;
    if (z > 64'sd3373259426) z = 64'sd3373259426;
    return z;
  endfunction

  function automatic longint angle_sine(longint th);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    if (th > 1686629713) th = 64'sd3373259426 - th;
    z = th;
    for (int i = 0; i < 30; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= angle_step(i);
      end else begin
        x += dx; y -= dy; z += angle_step(i);
      end
    end
    return y;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic ds_out_t slerp_predict(ds_in_t it);
    longint f [3];
    longint t [3];
    longint dot, c, s, a, ta, wa, wb, acc, bl;
    logic signed [15:0] r [3];
    ds_out_t o;
    f[0] = it.from_x; f[1] = it.from_y; f[2] = it.from_z;
    t[0] = it.to_x;   t[1] = it.to_y;   t[2] = it.to_z;
    bl = it.blend;
    if (bl > 65536) bl = 65536;
    dot = f[0] * t[0] + f[1] * t[1] + f[2] * t[2];
    if (dot > (64'sd1 << 28)) dot = 64'sd1 << 28;
    if (dot < -(64'sd1 << 28)) dot = -(64'sd1 << 28);
    c = dot * 4;
    s = root_floor((64'sd1 << 60) - c * c);
    if (s < 10737) begin
      for (int j = 0; j < 3; j++) r[j] = t[j][15:0];
    end else begin
      a = pair_angle(c, s);
      ta = (a * bl) >>> 16;
      wa = (angle_sine(a - ta) * ANGLE_ONE) / s;
      wb = (angle_sine(ta) * ANGLE_ONE) / s;
      for (int j = 0; j < 3; j++) begin
        acc = wa * f[j] + wb * t[j] + (64'sd1 << 29);
        r[j] = clip16(acc >>> 30);
      end
    end
    o.out_x = r[0]; o.out_y = r[1]; o.out_z = r[2];
    return o;
  endfunction

  always @(posedge clk) begin
    ds_out_t e;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (slerp_results.size() == 0) begin
          $error("unexpected result %p", out_item);
          errs++;
        end else begin
          e = slerp_results.pop_front();
          if (out_item.out_x !== e.out_x) begin
            $error("out_x expected %0d actual %0d", e.out_x, out_item.out_x);
            errs++;
          end
          if (out_item.out_y !== e.out_y) begin
            $error("out_y expected %0d actual %0d", e.out_y, out_item.out_y);
            errs++;
          end
          if (out_item.out_z !== e.out_z) begin
            $error("out_z expected %0d actual %0d", e.out_z, out_item.out_z);
            errs++;
          end
        end
      end
      if (start && !busy) slerp_results.push_back(slerp_predict(in_item));
      fail_count <= fail_count + errs;
    end
    pending <= slerp_results.size();
  end
endmodule

// ===== bench/testbench.sv =====
// Top of the direction slerp bench: clock, reset, vector-pair stimulus and verdict.
// Depends on ds_pkg, direction_slerp and direction_slerp_checker.
module testbench;
  import ds_pkg::*;

  localparam int ITEMS = 850;
  localparam int LIMIT = 2000;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  ds_in_t  in_item = '0;
  logic    out_valid;
  ds_out_t out_item;
  int      fail_count;
  int      pending;
  int      idle_cycles = 0;

  always #2 clk = ~clk;

  direction_slerp DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  direction_slerp_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [15:0] unit_part();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 16'($signed($urandom_range(0, 32768)) - 16384);
    if (sel < 8) return 16'($urandom);
    return (sel == 8) ? 16'h7fff : 16'h8000;
  endfunction

  function automatic ds_in_t random_pair();
    ds_in_t it;
    int mode;
    it.from_x = unit_part(); it.from_y = unit_part(); it.from_z = unit_part();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      it.to_x = it.from_x; it.to_y = it.from_y; it.to_z = it.from_z;
    end else if (mode == 1) begin
      it.to_x = -it.from_x; it.to_y = -it.from_y; it.to_z = -it.from_z;
    end else begin
      it.to_x = unit_part(); it.to_y = unit_part(); it.to_z = unit_part();
    end
    case ($urandom_range(0, 7))
      0: it.blend = 17'd0;
      1: it.blend = 17'd65536;
      2: it.blend = 17'($urandom);
      default: it.blend = 17'($urandom_range(0, 65536));
    endcase
    return it;
  endfunction

  task automatic send_pair(ds_in_t it, bit allow_gap);
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic ds_in_t make_pair(int fx, int fy, int fz, int tx, int ty, int tz,
                                       int bl);
    ds_in_t it;
    it.from_x = 16'(fx); it.from_y = 16'(fy); it.from_z = 16'(fz);
    it.to_x = 16'(tx); it.to_y = 16'(ty); it.to_z = 16'(tz);
    it.blend = 17'(bl);
    return it;
  endfunction

  initial begin
    ds_in_t directed [$];
    int wait_cycles;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed.push_back(make_pair(16384, 0, 0, 0, 16384, 0, 32768));
    directed.push_back(make_pair(16384, 0, 0, 0, 16384, 0, 0));
    directed.push_back(make_pair(16384, 0, 0, 0, 16384, 0, 65536));
    directed.push_back(make_pair(16384, 0, 0, 0, 16384, 0, 131071));
    directed.push_back(make_pair(16384, 0, 0, 16384, 0, 0, 20000));
    directed.push_back(make_pair(16384, 0, 0, -16384, 0, 0, 20000));
    directed.push_back(make_pair(16384, 0, 0, -11585, 11585, 0, 40000));
    directed.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 1));
    directed.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, 32767, 65535));
    directed.push_back(make_pair(-32768, 32767, -32768, 32767, -32768, 0, 65537));
    directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 30000));
    directed.push_back(make_pair(0, 0, 0, 16384, 0, 0, 30000));
    directed.push_back(make_pair(0, 0, 16384, 0, 16384, 0, 50000));
    directed.push_back(make_pair(16384, 0, 0, 16384, 1, 0, 30000));
    directed.push_back(make_pair(100, 200, -300, -50, 400, 7, 12345));
    directed.push_back(make_pair(32767, -32768, 1, -1, 32767, -32768, 98304));
    foreach (directed[i]) send_pair(directed[i], 1'b0);
    for (int n = 0; n < ITEMS; n++) send_pair(random_pair(), n < ITEMS - 100);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 200) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
